// File: rtl/core/plq_pkg.sv
// Package for the packet length queue: field widths, operation codes and
// the default queue depth. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plq_pkg;

  // Default number of queued lengths
  localparam int unsigned QueueDepth = 64;

  // Field widths at the block's ports
  localparam int unsigned OpW       = 2;
  localparam int unsigned LenW      = 32;
  localparam int unsigned TotalW    = 38;
  localparam int unsigned CountOutW = 7;

  // Operation codes carried by op
  typedef enum logic [OpW-1:0] {
    OP_ADD     = 2'd0,
    OP_CONSUME = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

endpackage

`default_nettype wire

// File: rtl/core/plq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Read-before-write on an address collision. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module plq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/packet_length_queue_consume.sv
// Packet length queue top level: sequencer, pointers and running total
// around one length RAM. Depends on plq_pkg and plq_ram.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries op_i and length_value_i.
//   An add appends a length, a consume takes a byte grant from the head
//   across entries and drops emptied heads, a clear empties the queue.
//   Output channel (out_valid_o / out_ready_i) returns exactly one result
//   per input transaction: status, entry count, head length, running total
//   and, for a consume, the remaining bytes of the last head touched.
//   Sequence: add, clear and unused codes pass from acceptance through
//   S_HEAD (head read) and S_HL to S_OUT, where the result is presented; a
//   consume with a nonzero grant on a non-empty queue first visits head
//   entries in S_RD and S_EVAL. Each visit is a read of the length RAM
//   followed by a modify and write-back, so the single RAM read port sets
//   the pace. A further input is taken the cycle after the result has been
//   taken; no new input is accepted while an earlier one is in progress.
//   Reset empties the queue (count, total and head pointer to zero); the RAM
//   contents are left as they are, since only written entries are used.
//   While the receiver stalls the result is held stable and no new input
//   transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none

module packet_length_queue_consume #(
  parameter int unsigned QUEUE_DEPTH = plq_pkg::QueueDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [plq_pkg::OpW-1:0]        op_i,
  input  wire logic [plq_pkg::LenW-1:0]       length_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                status_o,
  output logic      [plq_pkg::CountOutW-1:0]  entry_count_o,
  output logic      [plq_pkg::LenW-1:0]       head_length_o,
  output logic      [plq_pkg::TotalW-1:0]     total_bytes_o,
  output logic      [plq_pkg::LenW-1:0]       head_remaining_o
);

  import plq_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = PtrW + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_EVAL = 6'b000100,
    S_HEAD = 6'b001000,
    S_HL   = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [PtrW-1:0]     head_q, head_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [TotalW-1:0]   total_q, total_d;
  logic [LenW-1:0]     grant_q, grant_d;
  logic                status_q, status_d;
  logic [LenW-1:0]     remain_q, remain_d;
  logic [LenW-1:0]     headlen_q, headlen_d;

  logic                ram_wr_en;
  logic [PtrW-1:0]     ram_wr_addr;
  logic [LenW-1:0]     ram_wr_data;
  logic                ram_rd_en;
  logic [LenW-1:0]     ram_rd_data;

  logic [SumW-1:0]     tail_sum;
  logic [PtrW-1:0]     tail_idx;
  logic [PtrW-1:0]     head_next;
  logic                full;
  logic [LenW-1:0]     taken;
  logic [LenW-1:0]     left;

  // Tail index: head plus count, wrapped once around the depth
  assign tail_sum  = SumW'(head_q) + SumW'(count_q);
  assign tail_idx  = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                     PtrW'(tail_sum - SumW'(QUEUE_DEPTH)) : PtrW'(tail_sum);
  assign head_next = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign full      = (count_q >= CntW'(QUEUE_DEPTH));

  // Bytes taken from the head entry just read
  assign taken = (ram_rd_data >= grant_q) ? grant_q : ram_rd_data;
  assign left  = ram_rd_data - taken;

  plq_ram #(
    .Width (LenW),
    .Depth (QUEUE_DEPTH)
  ) u_len_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (head_q),
    .rd_data_o (ram_rd_data)
  );

  // Sequencer: decode, walk the head entries, fetch the head for the result
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    total_d     = total_q;
    grant_d     = grant_q;
    status_d    = status_q;
    remain_d    = remain_q;
    headlen_d   = headlen_q;
    ram_wr_en   = 1'b0;
    ram_wr_addr = head_q;
    ram_wr_data = left;
    ram_rd_en   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = 1'b0;
          remain_d = '0;
          grant_d  = length_value_i;
          state_d  = S_HEAD;
          unique case (op_i)
            OP_ADD: begin
              if (full) begin
                status_d = 1'b1;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = tail_idx;
                ram_wr_data = length_value_i;
                count_d     = count_q + 1'b1;
                total_d     = total_q + TotalW'(length_value_i);
              end
            end
            OP_CONSUME: begin
              if ((length_value_i != '0) && (count_q != '0) && (total_q != '0)) begin
                state_d = S_RD;
              end
            end
            OP_CLEAR: begin
              head_d  = '0;
              count_d = '0;
              total_d = '0;
            end
            default: begin
              state_d = S_HEAD;
            end
          endcase
        end
      end

      S_RD: begin
        ram_rd_en = 1'b1;
        state_d   = S_EVAL;
      end

      S_EVAL: begin
        state_d = S_HEAD;
        if (ram_rd_data == '0) begin
          // Drop an empty head and look at the next one
          head_d  = head_next;
          count_d = count_q - 1'b1;
          if (count_q != CntW'(1)) begin
            state_d = S_RD;
          end
        end else if ((grant_q != '0) && (total_q != '0)) begin
          // Take bytes from the head and write back what is left
          ram_wr_en = 1'b1;
          grant_d   = grant_q - taken;
          total_d   = total_q - TotalW'(taken);
          remain_d  = left;
          if (left == '0) begin
            head_d  = head_next;
            count_d = count_q - 1'b1;
            if (count_q != CntW'(1)) begin
              state_d = S_RD;
            end
          end
        end
      end

      S_HEAD: begin
        ram_rd_en = 1'b1;
        state_d   = S_HL;
      end

      S_HL: begin
        headlen_d = (count_q == '0) ? '0 : ram_rd_data;
        state_d   = S_OUT;
      end

      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    grant_q   <= grant_d;
    status_q  <= status_d;
    remain_q  <= remain_d;
    headlen_q <= headlen_d;
  end

  // Drive the channels
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_OUT);
  assign status_o         = status_q;
  assign entry_count_o    = CountOutW'(count_q);
  assign head_length_o    = headlen_q;
  assign total_bytes_o    = total_q;
  assign head_remaining_o = remain_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (count_q == '0)) |-> (head_length_o == '0))
    else $error("empty queue reports a head length");

  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == OP_ADD) && !full)
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("accepted add did not grow the queue");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (count_q == CntW'(QUEUE_DEPTH)))
    else $error("drop flagged with room in the queue");

endmodule

`default_nettype wire
